// ===== sv/lmrq_pkg.sv =====
package lmrq_pkg;

  // Defaults for the top level parameters
  localparam int unsigned DEF_QUEUE_DEPTH = 8;
  localparam int unsigned DEF_ROW_COUNT   = 8;

  // Field widths
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned PCT_W     = 8;
  localparam int unsigned LEN_W     = 12;
  localparam int unsigned LEVEL_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_BYTES  = 2'd1;
  localparam logic [LEN_W-1:0]     ROW_BYTES_RST = 12'd24;
  localparam logic [LEN_W-1:0]     BG_BYTES_RST  = 12'd18;

  // Background level scaling
  localparam int unsigned LEVEL_MAX = 63;
  localparam int unsigned PCT_FULL  = 100;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ROW  = 2'd1,
    ACT_BG   = 2'd2,
    ACT_DONE = 2'd3
  } act_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [ROW_W-1:0] row;
    logic [PCT_W-1:0] percent;
  } in_item_t;

  typedef struct packed {
    logic               start_send;
    logic               send_background;
    logic [ROW_W-1:0]   send_row;
    logic [LEN_W-1:0]   send_length;
    logic               select_background;
    logic               latch_pulse;
    logic [ROW_W-1:0]   lit_row;
    logic [LEVEL_W-1:0] background_level;
    logic               queue_overflow;
    logic               queue_empty;
    logic               spurious_done;
  } out_item_t;

  // Queue entry: background kind flag and row number
  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] row;
  } entry_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic cfg_we;
  } ctrl_cmd_t;

endpackage

// ===== sv/led_matrix_row_refresh_queue.sv =====
// Channel   Direction  Handshake                    Payload
// --------  ---------  ---------------------------  ----------------------------
// command   in         start & !busy                item_i (in_item_t)
// result    out        res_valid_o, one cycle       res_o (out_item_t)
// config    in         cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//
// Each item has an accept cycle and a busy cycle: the accept cycle issues the
// queue RAM read of the entry after the head, the next cycle (busy high) uses
// the registered read data and updates the queue. The result beat follows in
// the cycle after, and a new command may be accepted in that same cycle.
// Reset is asynchronous, active low; the queue RAM needs no clearing pass.
// The result side cannot stall: every beat is taken in its single cycle.
module led_matrix_row_refresh_queue
  import lmrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned ROW_COUNT   = DEF_ROW_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command beat
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item_i,
  // result beat
  output logic                 res_valid_o,
  output out_item_t            res_o,
  // configuration beat
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_data_i
);

  ctrl_cmd_t cmd;

  // Sequencer: idle / execute, plus the result strobe
  lmrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .cfg_valid_i(cfg_valid_i),
    .cmd_o      (cmd),
    .busy       (busy),
    .cfg_ready_o(cfg_ready_o),
    .res_valid_o(res_valid_o)
  );

  // Queue, scan row, select line, byte count registers and result register
  lmrq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ROW_COUNT  (ROW_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .item_i     (item_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res_o)
  );

  // A result beat always lands with the sequencer back at idle
  a_res_when_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni) res_valid_o |-> !busy
  ) else $error("result beat while busy");

  // An accepted command yields a result beat after its execute cycle
  a_res_follows: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> ##1 res_valid_o
  ) else $error("missing result beat");

  // A flush never starts a transfer
  a_overflow_no_start: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (res_valid_o && res_o.queue_overflow) |-> (!res_o.start_send && res_o.queue_empty)
  ) else $error("transfer started on overflow");

  // An ignored done neither latches nor starts anything
  a_spurious_quiet: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (res_valid_o && res_o.spurious_done) |-> (!res_o.latch_pulse && !res_o.start_send)
  ) else $error("spurious done had an effect");

endmodule

// ===== sv/lmrq_ram.sv =====
module lmrq_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lmrq_ctrl.sv =====
module lmrq_ctrl
  import lmrq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      cfg_valid_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy,
  output logic      cfg_ready_o,
  output logic      res_valid_o
);

  state_e state_q, state_d;
  logic   res_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    busy        = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load   = start;
        cmd_o.cfg_we = cfg_valid_i;
        cfg_ready_o  = 1'b1;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        busy       = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= cmd_o.exec;
    end
  end

  assign res_valid_o = res_valid_q;

endmodule

// ===== sv/lmrq_datapath.sv =====
module lmrq_datapath
  import lmrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned ROW_COUNT   = DEF_ROW_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  input  in_item_t             item_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_data_i,
  output out_item_t            res_o
);

  localparam int unsigned IdxW       = $clog2(QUEUE_DEPTH);
  localparam int unsigned OccW       = IdxW + 1;
  localparam int unsigned LevelShift = 19;
  // ceil(2^19 / 100) folded with the 63 scale; exact for percent below 100
  localparam int unsigned LevelMul   = LEVEL_MAX * (((1 << LevelShift) + PCT_FULL - 1) / PCT_FULL);
  localparam int unsigned ProdW      = PCT_W + $clog2(LevelMul + 1);

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    return (idx == IdxW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  in_item_t         item_q;
  logic [LEN_W-1:0] row_bytes_q, bg_bytes_q;
  logic [IdxW-1:0]  head_q, head_d, tail_q, tail_d;
  logic             sending_q, sending_d;
  logic [ROW_W-1:0] scan_q, scan_d, scan_next;
  logic             select_q, select_d;
  out_item_t        res_q, res;

  logic [OccW-1:0]    occ;
  logic               full;
  logic               enq, do_start, ram_we;
  entry_t             enq_entry, start_entry, head_entry;
  logic [ProdW-1:0]   pct_prod;
  logic [LEVEL_W-1:0] level;
  logic [$bits(entry_t)-1:0] ram_rdata;

  // Only the entry after the head is ever fetched: when idle the queue is empty,
  // so an enqueue starts the entry it has just written.
  lmrq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(enq_entry),
    .raddr_i(idx_inc(head_q)),
    .rdata_o(ram_rdata)
  );

  assign head_entry = entry_t'(ram_rdata);

  assign occ = (tail_q >= head_q) ?
               ({1'b0, tail_q} - {1'b0, head_q}) :
               ({1'b0, tail_q} + OccW'(QUEUE_DEPTH) - {1'b0, head_q});
  assign full = (occ >= OccW'(QUEUE_DEPTH - 2));

  assign scan_next = (scan_q == ROW_W'(ROW_COUNT - 1)) ? '0 : scan_q + 1'b1;

  assign pct_prod = ProdW'(item_q.percent) * ProdW'(LevelMul);
  assign level    = (item_q.percent >= PCT_W'(PCT_FULL)) ?
                    LEVEL_W'(LEVEL_MAX) : pct_prod[LevelShift +: LEVEL_W];

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    sending_d   = sending_q;
    scan_d      = scan_q;
    select_d    = select_q;
    res         = '0;
    enq         = 1'b0;
    enq_entry   = '0;
    ram_we      = 1'b0;
    do_start    = 1'b0;
    start_entry = '0;

    case (act_e'(item_q.action))
      ACT_TICK: begin
        scan_d        = scan_next;
        enq           = 1'b1;
        enq_entry.row = scan_next;
      end
      ACT_ROW: begin
        if ({1'b0, item_q.row} < (ROW_W + 1)'(ROW_COUNT)) begin
          enq           = 1'b1;
          enq_entry.row = item_q.row;
        end
      end
      ACT_BG: begin
        res.background_level = level;
        enq                  = 1'b1;
        enq_entry.kind       = 1'b1;
      end
      ACT_DONE: begin
        if (!sending_q) begin
          res.spurious_done = 1'b1;
        end else begin
          select_d        = 1'b0;
          res.latch_pulse = 1'b1;
          res.lit_row     = scan_q;
          if (head_q != tail_q) begin
            head_d = idx_inc(head_q);
          end
          sending_d = 1'b0;
          if (head_d != tail_q) begin
            do_start    = 1'b1;
            start_entry = head_entry;
          end
        end
      end
      default: ;
    endcase

    if (enq) begin
      if (full) begin
        head_d             = '0;
        tail_d             = '0;
        sending_d          = 1'b0;
        res.queue_overflow = 1'b1;
      end else begin
        ram_we = cmd_i.exec;
        tail_d = idx_inc(tail_q);
        if (!sending_q) begin
          do_start    = 1'b1;
          start_entry = enq_entry;
        end
      end
    end

    if (do_start) begin
      sending_d           = 1'b1;
      select_d            = start_entry.kind;
      res.start_send      = 1'b1;
      res.send_background = start_entry.kind;
      res.send_row        = start_entry.kind ? '0 : start_entry.row;
      res.send_length     = start_entry.kind ? bg_bytes_q : row_bytes_q;
    end

    res.select_background = select_d;
    res.queue_empty       = (head_d == tail_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= ROW_BYTES_RST;
      bg_bytes_q  <= BG_BYTES_RST;
      head_q      <= '0;
      tail_q      <= '0;
      sending_q   <= 1'b0;
      scan_q      <= '0;
      select_q    <= 1'b0;
    end else begin
      if (cmd_i.cfg_we) begin
        case (cfg_index_i)
          CFG_ROW_BYTES: row_bytes_q <= cfg_data_i;
          CFG_BG_BYTES:  bg_bytes_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        head_q    <= head_d;
        tail_q    <= tail_d;
        sending_q <= sending_d;
        scan_q    <= scan_d;
        select_q  <= select_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      res_q <= res;
    end
  end

  assign res_o = res_q;

endmodule

// ===== tb/sv/led_matrix_row_refresh_queue_tb.sv =====
module led_matrix_row_refresh_queue_tb
  import lmrq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH = DEF_QUEUE_DEPTH;
  localparam int unsigned NROWS  = DEF_ROW_COUNT;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  // Each command needs an accept and an execute cycle, plus the sender's gaps.
  // Bounded many times over.
  localparam int unsigned CYCLE_LIMIT = 100000;
  // Settle time after the last result: issue, update and result stages.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 120;

  logic            clk_i;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  in_item_t        item_i      = '0;
  logic            res_valid_o;
  out_item_t       res_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [LEN_W-1:0]     cfg_data_i  = '0;

  led_matrix_row_refresh_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Scan controller shadow: ring of pending transfers, scan row, select line
  // and the two byte counts, updated once per accepted command beat.
  // ---------------------------------------------------------------------------
  entry_t               m_slots [QDEPTH];
  logic [PTR_W-1:0]     m_head;
  logic [PTR_W-1:0]     m_tail;
  logic                 m_busy;
  logic [ROW_W-1:0]     m_scan;
  logic                 m_select;
  logic [LEN_W-1:0]     m_row_len;
  logic [LEN_W-1:0]     m_bg_len;

  in_item_t  cmd_backlog[$];      // commands waiting for the driver
  out_item_t predicted_beats[$];  // result beats owed by the block, oldest first
  int unsigned idle_pct = 29;     // chance in a hundred that the driver holds off
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  function automatic void clear_shadow();
    foreach (m_slots[i]) m_slots[i] = '0;
    m_head    = '0;
    m_tail    = '0;
    m_busy    = 1'b0;
    m_scan    = '0;
    m_select  = 1'b0;
    m_row_len = ROW_BYTES_RST;
    m_bg_len  = BG_BYTES_RST;
  endfunction

  // Head entry goes out; the select line follows its kind.
  function automatic void launch_head(inout out_item_t r);
    entry_t e;
    e = m_slots[m_head];
    m_busy            = 1'b1;
    m_select          = e.kind;
    r.start_send      = 1'b1;
    r.send_background = e.kind;
    if (e.kind) begin
      r.send_length = m_bg_len;
    end else begin
      r.send_row    = e.row;
      r.send_length = m_row_len;
    end
  endfunction

  // Full ring (depth minus two in use): drop everything and go idle.
  function automatic void queue_request(entry_t e, inout out_item_t r);
    logic [PTR_W-1:0] used;
    used = m_tail - m_head;
    if (used >= QDEPTH - 2) begin
      m_head           = '0;
      m_tail           = '0;
      m_busy           = 1'b0;
      r.queue_overflow = 1'b1;
    end else begin
      m_slots[m_tail] = e;
      m_tail          = m_tail + 1'b1;
    end
    if (!m_busy && m_head != m_tail) launch_head(r);
  endfunction

  function automatic out_item_t refresh_step(in_item_t it);
    out_item_t   r;
    entry_t      e;
    int unsigned pct;
    r   = '0;
    e   = '0;
    pct = it.percent;
    case (it.action)
      ACT_TICK: begin
        m_scan = ROW_W'((int'(m_scan) + 1) % NROWS);
        e.row  = m_scan;
        queue_request(e, r);
      end
      ACT_ROW: begin
        // rows beyond the panel are dropped without a trace
        if (it.row < NROWS) begin
          e.row = it.row;
          queue_request(e, r);
        end
      end
      ACT_BG: begin
        r.background_level = LEVEL_W'((pct >= PCT_FULL) ? LEVEL_MAX
                                                       : pct * LEVEL_MAX / PCT_FULL);
        e.kind = 1'b1;
        queue_request(e, r);
      end
      default: begin
        if (!m_busy) begin
          // done with nothing in flight: flagged, otherwise ignored
          r.spurious_done = 1'b1;
        end else begin
          m_select      = 1'b0;
          r.latch_pulse = 1'b1;
          r.lit_row     = m_scan;
          if (m_head != m_tail) m_head = m_head + 1'b1;
          m_busy = 1'b0;
          if (m_head != m_tail) launch_head(r);
        end
      end
    endcase
    r.select_background = m_select;
    r.queue_empty       = (m_head == m_tail);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: a beat goes through on an edge with start high and busy
  // low. The shadow is stepped on that same edge, so the forecast is queued
  // long before the matching result beat can appear.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start  <= 1'b0;
      item_i <= '0;
    end else begin
      if (start && !busy) predicted_beats.push_back(refresh_step(item_i));
      // a beat held off by busy stays on the port untouched
      if (!(start && busy)) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start  <= 1'b1;
          item_i <= cmd_backlog.pop_front();
        end else begin
          start  <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: each strobe is one beat, compared field by field with the
  // oldest forecast.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && res_valid_o) begin
      if (predicted_beats.size() == 0) begin
        $error("result beat with no forecast outstanding");
        mismatches++;
      end else begin
        want = predicted_beats.pop_front();
        check_field("start_send",        want.start_send,        res_o.start_send);
        check_field("send_background",   want.send_background,   res_o.send_background);
        check_field("send_row",          want.send_row,          res_o.send_row);
        check_field("send_length",       want.send_length,       res_o.send_length);
        check_field("select_background", want.select_background, res_o.select_background);
        check_field("latch_pulse",       want.latch_pulse,       res_o.latch_pulse);
        check_field("lit_row",           want.lit_row,           res_o.lit_row);
        check_field("background_level",  want.background_level,  res_o.background_level);
        check_field("queue_overflow",    want.queue_overflow,    res_o.queue_overflow);
        check_field("queue_empty",       want.queue_empty,       res_o.queue_empty);
        check_field("spurious_done",     want.spurious_done,     res_o.spurious_done);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void push_cmd(act_e a, int unsigned row, int unsigned pct);
    in_item_t it;
    it.action  = a;
    it.row     = ROW_W'(row);
    it.percent = PCT_W'(pct);
    cmd_backlog.push_back(it);
  endfunction

  // Random command; the share of send-done beats sets how full the ring runs.
  function automatic in_item_t random_cmd(int unsigned done_pct);
    in_item_t it;
    it.row     = ROW_W'($urandom_range(NROWS - 1));
    // half the percents crowd round the saturation point
    it.percent = PCT_W'($urandom_range(1) ? $urandom_range(255) : $urandom_range(110, 90));
    if ($urandom_range(99) < done_pct) it.action = ACT_DONE;
    else it.action = 2'($urandom_range(2));
    return it;
  endfunction

  // Wait for every command to go in and every result beat to come back.
  task automatic drain();
    while (cmd_backlog.size() != 0 || start || predicted_beats.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both byte counts, back to back; only called with the block idle.
  task automatic set_lengths(logic [LEN_W-1:0] row_bytes, logic [LEN_W-1:0] bg_bytes);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_ROW_BYTES;
    cfg_data_i  <= row_bytes;
    do @(posedge clk_i); while (!cfg_ready_o);
    m_row_len   = row_bytes;
    cfg_index_i <= CFG_BG_BYTES;
    cfg_data_i  <= bg_bytes;
    do @(posedge clk_i); while (!cfg_ready_o);
    m_bg_len    = bg_bytes;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [LEN_W-1:0] row_bytes;
    logic [LEN_W-1:0] bg_bytes;
    int unsigned      done_pct;

    clear_shadow();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass at reset byte counts.
    push_cmd(ACT_DONE, 0, 0);          // done while idle
    push_cmd(ACT_TICK, 0, 0);
    push_cmd(ACT_ROW, 0, 0);
    push_cmd(ACT_ROW, 7, 255);
    push_cmd(ACT_BG, 0, 0);            // darkest level
    push_cmd(ACT_BG, 0, 99);           // just below saturation
    push_cmd(ACT_BG, 7, 100);          // saturates
    push_cmd(ACT_BG, 0, 255);
    repeat (6) push_cmd(ACT_DONE, 0, 0);   // all spurious: the ring overflowed on BG 255
    repeat (7) push_cmd(ACT_TICK, 0, 0);   // ring fills, seventh overflows
    push_cmd(ACT_BG, 0, 1);
    push_cmd(ACT_ROW, 5, 0);
    repeat (2) push_cmd(ACT_DONE, 0, 0);
    drain();

    // Random phases, each under its own byte counts.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin row_bytes = 12'd1;    bg_bytes = 12'd4095; done_pct = 25; end
        1: begin row_bytes = 12'd4095; bg_bytes = 12'd1;    done_pct = 35; end
        3: begin row_bytes = 12'd4095; bg_bytes = 12'd4095; done_pct = 45; end
        default: begin
          row_bytes = LEN_W'($urandom_range(4095, 1));
          bg_bytes  = LEN_W'($urandom_range(4095, 1));
          done_pct  = $urandom_range(40, 15);
        end
      endcase
      // one phase runs the sender flat out
      idle_pct = (p == 2) ? 0 : 29;
      set_lengths(row_bytes, bg_bytes);
      repeat (PHASE_ITEMS) cmd_backlog.push_back(random_cmd(done_pct));
      drain();
    end

    if (mismatches == 0 && predicted_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
